FILE: rtl/relay_command_supervisor_macros.svh
// Assertion macros for the relay command supervisor.
// Used by rcs_core; the bodies drop out when SYNTHESIS is set.
`ifndef RELAY_COMMAND_SUPERVISOR_MACROS_SVH
`define RELAY_COMMAND_SUPERVISOR_MACROS_SVH
`ifndef SYNTHESIS
`define RCS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define RCS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define RCS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RCS_ASSERT(lbl, clk, rstn, prop, msg)
`define RCS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define RCS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: rtl/rcs_pkg.sv
// Package for the relay command supervisor: types, codes and reset values.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rcs_pkg;

    localparam int RETRY_PERIOD_DEF = 100;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;
    localparam int PADDR_W     = 5;

    localparam logic [12:0] INIT_TICKS_RST       = 13'd6000;
    localparam logic [13:0] TIMEOUT_TICKS_RST    = 14'd10000;
    localparam logic [12:0] HOLD_OPEN_TICKS_RST  = 13'd4000;
    localparam logic [12:0] HOLD_OTHER_TICKS_RST = 13'd1000;
    localparam logic [5:0]  DISPATCH_TICKS_RST   = 6'd50;

    localparam logic [12:0] HOLD_MAX = 13'h1FFF;

    // register indexes, taken from paddr[4:2]
    localparam logic [2:0] REG_INIT_TICKS       = 3'd0;
    localparam logic [2:0] REG_TIMEOUT_TICKS    = 3'd1;
    localparam logic [2:0] REG_HOLD_OPEN_TICKS  = 3'd2;
    localparam logic [2:0] REG_HOLD_OTHER_TICKS = 3'd3;
    localparam logic [2:0] REG_DISPATCH_TICKS   = 3'd4;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_OPEN  = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    typedef enum logic [2:0] {
        RS_IDLE     = 3'd0,
        RS_INVALID  = 3'd1,
        RS_RUNNING  = 3'd2,
        RS_FINISHED = 3'd3,
        RS_TIMEOUT  = 3'd4
    } run_state_t;

    typedef struct packed {
        logic        cmd_enable;
        logic [15:0] cmd_serial;
        logic [1:0]  cmd_mode;
        logic        fb_update;
        logic [1:0]  fb_mode;
    } in_t;

    typedef struct packed {
        logic [12:0] init_ticks;
        logic [13:0] timeout_ticks;
        logic [12:0] hold_open_ticks;
        logic [12:0] hold_other_ticks;
        logic [5:0]  dispatch_ticks;
    } cfg_t;

    typedef struct packed {
        logic       send_now;
        logic       send_write;
        logic [1:0] send_mode;
        run_state_t run_state;
        logic       ready_res;
    } res_t;

endpackage

FILE: rtl/rcs_cfg.sv
// Configuration registers behind the APB-style port, with read back.
// Also keeps timeout_ticks modulo the retry period; depends on rcs_pkg.
`timescale 1ns / 1ps

module rcs_cfg #(
    parameter int RETRY_PERIOD = rcs_pkg::RETRY_PERIOD_DEF,
    localparam int PH_W = $clog2(RETRY_PERIOD)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rcs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output rcs_pkg::cfg_t               cfg,
    output logic [PH_W-1:0]             timeout_phase
);

    // reciprocal for the remainder of a 14-bit value
    localparam int MOD_S = 14;
    localparam int MOD_M = (2 ** MOD_S) / RETRY_PERIOD;
    localparam logic [PH_W-1:0] PHASE_RST =
        PH_W'(int'(rcs_pkg::TIMEOUT_TICKS_RST) % RETRY_PERIOD);

    rcs_pkg::cfg_t   cfg_reg;
    logic [PH_W-1:0] phase_reg;
    logic            wr_en;
    logic [2:0]      idx;
    logic [13:0]     wr_val;
    logic [26:0]     prod;
    logic [13:0]     q_est;
    logic [13:0]     rem;
    logic [13:0]     rem_fix;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign wr_val = pwdata[13:0];

    // quotient estimate is exact or one short; one subtract fixes the remainder
    assign prod    = 27'(wr_val) * 27'(MOD_M);
    assign q_est   = {1'b0, prod[26:14]};
    assign rem     = wr_val - 14'(q_est * 14'(RETRY_PERIOD));
    assign rem_fix = (rem >= 14'(RETRY_PERIOD)) ? rem - 14'(RETRY_PERIOD) : rem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.init_ticks       <= rcs_pkg::INIT_TICKS_RST;
            cfg_reg.timeout_ticks    <= rcs_pkg::TIMEOUT_TICKS_RST;
            cfg_reg.hold_open_ticks  <= rcs_pkg::HOLD_OPEN_TICKS_RST;
            cfg_reg.hold_other_ticks <= rcs_pkg::HOLD_OTHER_TICKS_RST;
            cfg_reg.dispatch_ticks   <= rcs_pkg::DISPATCH_TICKS_RST;
            phase_reg                <= PHASE_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                rcs_pkg::REG_INIT_TICKS:       cfg_reg.init_ticks <= pwdata[12:0];
                rcs_pkg::REG_TIMEOUT_TICKS:
                begin
                    cfg_reg.timeout_ticks <= wr_val;
                    phase_reg             <= rem_fix[PH_W-1:0];
                end
                rcs_pkg::REG_HOLD_OPEN_TICKS:  cfg_reg.hold_open_ticks <= pwdata[12:0];
                rcs_pkg::REG_HOLD_OTHER_TICKS: cfg_reg.hold_other_ticks <= pwdata[12:0];
                rcs_pkg::REG_DISPATCH_TICKS:   cfg_reg.dispatch_ticks <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            rcs_pkg::REG_INIT_TICKS:       prdata = 32'(cfg_reg.init_ticks);
            rcs_pkg::REG_TIMEOUT_TICKS:    prdata = 32'(cfg_reg.timeout_ticks);
            rcs_pkg::REG_HOLD_OPEN_TICKS:  prdata = 32'(cfg_reg.hold_open_ticks);
            rcs_pkg::REG_HOLD_OTHER_TICKS: prdata = 32'(cfg_reg.hold_other_ticks);
            rcs_pkg::REG_DISPATCH_TICKS:   prdata = 32'(cfg_reg.dispatch_ticks);
            default:                       prdata = '0;
        endcase
    end

    assign cfg           = cfg_reg;
    assign timeout_phase = phase_reg;

endmodule

FILE: rtl/rcs_core.sv
// Supervisor state and its one-tick update: power-up, runs, retries, hold,
// timeout, idle polling and dispatch. Depends on rcs_pkg and the macro header.
`timescale 1ns / 1ps
`include "relay_command_supervisor_macros.svh"

module rcs_core #(
    parameter int RETRY_PERIOD = rcs_pkg::RETRY_PERIOD_DEF,
    localparam int PH_W = $clog2(RETRY_PERIOD)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  rcs_pkg::in_t      in_item,
    input  rcs_pkg::cfg_t     cfg,
    input  logic [PH_W-1:0]   timeout_phase,
    output rcs_pkg::res_t     res
);

    localparam int IDLE_W = $clog2(RETRY_PERIOD + 1);
    localparam logic [PH_W-1:0]   PH_LAST   = PH_W'(RETRY_PERIOD - 1);
    localparam logic [PH_W-1:0]   PH_HALF   = PH_W'(RETRY_PERIOD / 2);
    localparam logic [IDLE_W-1:0] IDLE_TOP  = IDLE_W'(RETRY_PERIOD);
    localparam logic [IDLE_W-1:0] IDLE_HALF = IDLE_W'(RETRY_PERIOD / 2);

    logic                init_done_reg,   init_done_next;
    logic [12:0]         init_count_reg,  init_count_next;
    logic [5:0]          disp_count_reg,  disp_count_next;
    logic [IDLE_W-1:0]   idle_phase_reg,  idle_phase_next;
    logic [15:0]         last_serial_reg, last_serial_next;
    rcs_pkg::run_state_t run_code_reg,    run_code_next;
    logic [13:0]         timeout_left_reg, timeout_left_next;
    logic [PH_W-1:0]     tphase_reg,      tphase_next;
    logic [12:0]         hold_count_reg,  hold_count_next;
    logic [12:0]         hold_limit_reg,  hold_limit_next;
    logic [1:0]          active_mode_reg, active_mode_next;
    logic [1:0]          seen_mode_reg,   seen_mode_next;
    logic                pend_write_reg,  pend_write_next;
    logic [1:0]          pend_mode_reg,   pend_mode_next;
    logic                hold_done;
    logic                send;

    always_comb
    begin
        init_done_next    = init_done_reg;
        init_count_next   = init_count_reg;
        idle_phase_next   = idle_phase_reg;
        last_serial_next  = last_serial_reg;
        run_code_next     = run_code_reg;
        timeout_left_next = timeout_left_reg;
        tphase_next       = tphase_reg;
        hold_count_next   = hold_count_reg;
        hold_limit_next   = hold_limit_reg;
        active_mode_next  = active_mode_reg;
        seen_mode_next    = seen_mode_reg;
        pend_write_next   = pend_write_reg;
        pend_mode_next    = pend_mode_reg;
        hold_done         = 1'b0;

        // fresh feedback lands first, also during power-up
        if (in_item.fb_update)
            seen_mode_next = in_item.fb_mode;

        if (!init_done_reg)
        begin
            if (init_count_reg < cfg.init_ticks)
                init_count_next = init_count_reg + 13'd1;
            else
            begin
                init_count_next = '0;
                init_done_next  = 1'b1;
            end
            pend_write_next = 1'b1;
            pend_mode_next  = rcs_pkg::MODE_OPEN;
        end
        else
        begin
            if (!in_item.cmd_enable)
                last_serial_next = '0;
            if (in_item.cmd_enable && (in_item.cmd_serial != last_serial_reg))
            begin
                last_serial_next = in_item.cmd_serial;
                hold_count_next  = '0;
                if (in_item.cmd_serial == '0)
                    run_code_next = rcs_pkg::RS_INVALID;
                else
                begin
                    run_code_next     = rcs_pkg::RS_RUNNING;
                    timeout_left_next = cfg.timeout_ticks;
                    tphase_next       = timeout_phase;
                    hold_limit_next   = (in_item.cmd_mode == rcs_pkg::MODE_OPEN) ?
                                        cfg.hold_open_ticks : cfg.hold_other_ticks;
                    active_mode_next  = in_item.cmd_mode;
                    seen_mode_next    = rcs_pkg::MODE_NONE;
                end
            end

            if (run_code_next == rcs_pkg::RS_RUNNING)
            begin
                if (timeout_left_next != '0)
                begin
                    // tphase tracks timeout_left modulo the retry period
                    timeout_left_next = timeout_left_next - 14'd1;
                    tphase_next = (tphase_next == '0) ? PH_LAST : tphase_next - PH_W'(1);
                    if (active_mode_next != seen_mode_next)
                    begin
                        if (tphase_next == '0)
                        begin
                            pend_write_next = 1'b1;
                            pend_mode_next  = active_mode_next;
                        end
                        else if (tphase_next == PH_HALF)
                        begin
                            pend_write_next = 1'b0;
                            pend_mode_next  = rcs_pkg::MODE_NONE;
                        end
                    end
                    else
                    begin
                        hold_done = (hold_count_next >= hold_limit_next);
                        if (hold_count_next != rcs_pkg::HOLD_MAX)
                            hold_count_next = hold_count_next + 13'd1;
                        pend_write_next = 1'b0;
                        pend_mode_next  = rcs_pkg::MODE_NONE;
                        if (hold_done)
                            run_code_next = rcs_pkg::RS_FINISHED;
                    end
                end
                else
                begin
                    pend_write_next = 1'b0;
                    pend_mode_next  = rcs_pkg::MODE_NONE;
                    run_code_next   = rcs_pkg::RS_TIMEOUT;
                end
            end
            else
            begin
                idle_phase_next = (idle_phase_reg < IDLE_TOP) ?
                                  idle_phase_reg + IDLE_W'(1) : '0;
                if ((idle_phase_next == '0) || (idle_phase_next == IDLE_TOP))
                begin
                    pend_write_next = 1'b0;
                    pend_mode_next  = rcs_pkg::MODE_NONE;
                end
                else if ((idle_phase_next == IDLE_HALF) &&
                         (seen_mode_next == rcs_pkg::MODE_OPEN))
                begin
                    pend_write_next = 1'b1;
                    pend_mode_next  = rcs_pkg::MODE_STOP;
                end
            end
        end
    end

    assign send            = (disp_count_reg >= cfg.dispatch_ticks);
    assign disp_count_next = send ? '0 : disp_count_reg + 6'd1;

    assign res.send_now   = send;
    assign res.send_write = pend_write_next;
    assign res.send_mode  = pend_mode_next;
    assign res.run_state  = run_code_next;
    assign res.ready_res  = init_done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_done_reg    <= 1'b0;
            init_count_reg   <= '0;
            disp_count_reg   <= '0;
            idle_phase_reg   <= '0;
            last_serial_reg  <= '0;
            run_code_reg     <= rcs_pkg::RS_IDLE;
            timeout_left_reg <= '0;
            tphase_reg       <= '0;
            hold_count_reg   <= '0;
            hold_limit_reg   <= '0;
            active_mode_reg  <= rcs_pkg::MODE_NONE;
            seen_mode_reg    <= rcs_pkg::MODE_NONE;
            pend_write_reg   <= 1'b0;
            pend_mode_reg    <= rcs_pkg::MODE_NONE;
        end
        else if (accept)
        begin
            init_done_reg    <= init_done_next;
            init_count_reg   <= init_count_next;
            disp_count_reg   <= disp_count_next;
            idle_phase_reg   <= idle_phase_next;
            last_serial_reg  <= last_serial_next;
            run_code_reg     <= run_code_next;
            timeout_left_reg <= timeout_left_next;
            tphase_reg       <= tphase_next;
            hold_count_reg   <= hold_count_next;
            hold_limit_reg   <= hold_limit_next;
            active_mode_reg  <= active_mode_next;
            seen_mode_reg    <= seen_mode_next;
            pend_write_reg   <= pend_write_next;
            pend_mode_reg    <= pend_mode_next;
        end
    end

    `RCS_ASSERT_IMP(a_run_after_init, clk, rst_n, run_code_reg != rcs_pkg::RS_IDLE, init_done_reg, "run state left idle during power-up")
    `RCS_ASSERT_IMP(a_timeout_spent, clk, rst_n, run_code_reg == rcs_pkg::RS_TIMEOUT, timeout_left_reg == '0, "timed out with ticks left")
    `RCS_ASSERT_NXT(a_init_request, clk, rst_n, accept && !init_done_reg, pend_write_reg && (pend_mode_reg == rcs_pkg::MODE_OPEN), "power-up request is not write OPEN")
    `RCS_ASSERT(a_phase_range, clk, rst_n, (tphase_reg <= PH_LAST) && (idle_phase_reg <= IDLE_TOP), "retry or idle phase out of range")

endmodule

FILE: rtl/rcs_out.sv
// Result register between the update logic and the output stream.
// Takes a new item while the held result is being taken; depends on rcs_pkg.
`timescale 1ns / 1ps

module rcs_out (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          accept,
    input  rcs_pkg::res_t res_in,
    output logic          m_tvalid,
    input  logic          m_tready,
    output rcs_pkg::res_t res_out
);

    logic          valid_reg;
    rcs_pkg::res_t res_reg;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (s_tready)
            valid_reg <= s_tvalid;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_in;
    end

    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

endmodule

FILE: rtl/relay_command_supervisor.sv
// Relay command supervisor: one result item for every input item (one tick).
// Latency: result valid on the cycle after the input item is accepted.
// Throughput: one item per cycle while m_tready is high; the single result register frees as it is taken.
// Reset (rst_n low, async): core state and output valid cleared, run state idle,
// power-up phase restarted, configuration registers back to their defaults.
`timescale 1ns / 1ps

module relay_command_supervisor #(
    parameter int RETRY_PERIOD = rcs_pkg::RETRY_PERIOD_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] cmd_enable, [16:1] cmd_serial, [18:17] cmd_mode, [19] fb_update,
    // [21:20] fb_mode, [23:22] zero
    input  logic [rcs_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] send_now, [1] send_write, [3:2] send_mode, [6:4] run_state, [7] ready_res
    output logic [rcs_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rcs_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int PH_W = $clog2(RETRY_PERIOD);

    rcs_pkg::in_t    in_item;
    rcs_pkg::cfg_t   cfg;
    rcs_pkg::res_t   res_next;
    rcs_pkg::res_t   res_q;
    logic [PH_W-1:0] timeout_phase;
    logic            accept;

    assign pready = 1'b1;

    assign in_item.cmd_enable = s_tdata[0];
    assign in_item.cmd_serial = s_tdata[16:1];
    assign in_item.cmd_mode   = s_tdata[18:17];
    assign in_item.fb_update  = s_tdata[19];
    assign in_item.fb_mode    = s_tdata[21:20];

    rcs_cfg #(
        .RETRY_PERIOD (RETRY_PERIOD)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .cfg           (cfg),
        .timeout_phase (timeout_phase)
    );

    rcs_core #(
        .RETRY_PERIOD (RETRY_PERIOD)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_item       (in_item),
        .cfg           (cfg),
        .timeout_phase (timeout_phase),
        .res           (res_next)
    );

    rcs_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .accept   (accept),
        .res_in   (res_next),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res_out  (res_q)
    );

    assign m_tdata = {res_q.ready_res, res_q.run_state, res_q.send_mode,
                      res_q.send_write, res_q.send_now};

endmodule
